FILE: src/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes for the double-ended queue
// Operation and status codes, controller states and the command and status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;

  localparam op_t OP_PUSH_BACK  = 3'd0;
  localparam op_t OP_PUSH_FRONT = 3'd1;
  localparam op_t OP_POP_FRONT  = 3'd2;
  localparam op_t OP_POP_BACK   = 3'd3;
  localparam op_t OP_PEEK_FRONT = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } stat_t;

endpackage

FILE: src/double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue of 32-bit words
// An accepted transaction passes through the execute and registered slot-RAM
// read steps of the sequencer before its result is loaded into the result
// register; a new transaction is not taken until the sequencer is idle again.
// A full result register that is not taken holds the sequencer in its read step.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_operation,
  input  logic signed [31:0]               in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               out_read_data,
  output logic [1:0]                       out_status,
  output logic                             out_now_empty,
  output logic                             out_now_full,
  output logic [4:0]                       out_occupancy
);

  dq_pkg::cmd_t  cmd;
  dq_pkg::stat_t stat;

  dq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .stat    (stat)
  );

  dq_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (in_operation),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data),
    .out_status   (out_status),
    .out_now_empty(out_now_empty),
    .out_now_full (out_now_full),
    .out_occupancy(out_occupancy)
  );

endmodule

FILE: src/dq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/dq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl: request sequencer
// Takes a transaction, runs it through execute and read, then loads the
// result register once it is free.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output dq_pkg::cmd_t  cmd,
  input  dq_pkg::stat_t stat
);

  dq_pkg::state_t state_r;
  dq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = dq_pkg::S_EXEC;
        end
      end
      dq_pkg::S_EXEC: begin
        state_nxt = dq_pkg::S_READ;
      end
      dq_pkg::S_READ: begin
        if (!stat.out_blocked) begin
          state_nxt = dq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      dq_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      dq_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      dq_pkg::S_READ: begin
        cmd.load_out = !stat.out_blocked;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/dq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath: ring pointers, slot memory and result register
// Holds the head index and word count, addresses the slot RAM and builds
// the result of each transaction.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dq_pkg::cmd_t                cmd,
  output dq_pkg::stat_t               stat,
  input  dq_pkg::op_t                 in_operation,
  input  logic signed [dq_pkg::DATA_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [dq_pkg::DATA_W-1:0] out_read_data,
  output dq_pkg::status_t             out_status,
  output logic                        out_now_empty,
  output logic                        out_now_full,
  output logic [dq_pkg::OCC_W-1:0]    out_occupancy
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  dq_pkg::op_t               op_r;
  logic [dq_pkg::DATA_W-1:0] value_r;
  logic [IW-1:0]             head_r;
  logic [IW-1:0]             head_nxt;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  dq_pkg::status_t           status_r;
  dq_pkg::status_t           status_nxt;
  logic                      rd_hit_r;
  logic                      rd_hit_nxt;
  logic                      out_valid_r;

  logic signed [dq_pkg::DATA_W-1:0] out_data_r;
  dq_pkg::status_t           out_status_r;
  logic                      out_empty_r;
  logic                      out_full_r;
  logic [dq_pkg::OCC_W-1:0]  out_occ_r;

  logic                      is_full;
  logic                      is_empty;
  logic [SW-1:0]             back_sum;
  logic [IW-1:0]             back_idx;
  logic [IW-1:0]             head_dec;
  logic [IW-1:0]             head_inc;
  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic                      ram_re;
  logic [IW-1:0]             ram_raddr;
  logic [dq_pkg::DATA_W-1:0] ram_rdata;

  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    back_sum = SW'(head_r) + SW'(count_r);
    if (op_r == dq_pkg::OP_POP_BACK) begin
      back_sum = back_sum - SW'(1);
    end
    if (back_sum >= SW'(DEPTH)) begin
      back_sum = back_sum - SW'(DEPTH);
    end
    back_idx = IW'(back_sum);
    head_dec = (head_r == '0) ? IW'(DEPTH - 1) : head_r - IW'(1);
    head_inc = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + IW'(1);
  end

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = dq_pkg::ST_OK;
    rd_hit_nxt = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = back_idx;
    ram_re     = 1'b0;
    ram_raddr  = head_r;
    unique case (op_r)
      dq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = dq_pkg::ST_FULL;
        end else begin
          ram_we    = cmd.exec;
          count_nxt = count_r + CW'(1);
        end
      end
      dq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = dq_pkg::ST_FULL;
        end else begin
          ram_we    = cmd.exec;
          ram_waddr = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          ram_re     = cmd.exec;
          rd_hit_nxt = 1'b1;
          head_nxt   = head_inc;
          count_nxt  = count_r - CW'(1);
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (is_empty) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          ram_re     = cmd.exec;
          ram_raddr  = back_idx;
          rd_hit_nxt = 1'b1;
          count_nxt  = count_r - CW'(1);
        end
      end
      dq_pkg::OP_PEEK_FRONT: begin
        if (is_empty) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          ram_re     = cmd.exec;
          rd_hit_nxt = 1'b1;
        end
      end
      default: begin
        status_nxt = dq_pkg::ST_OK;
      end
    endcase
  end

  dq_ram #(
    .WIDTH(dq_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(value_r),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      value_r <= in_value;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      rd_hit_r <= rd_hit_nxt;
    end
    if (cmd.load_out) begin
      out_data_r   <= rd_hit_r ? ram_rdata : '0;
      out_status_r <= status_r;
      out_empty_r  <= is_empty;
      out_full_r   <= is_full;
      out_occ_r    <= dq_pkg::OCC_W'(count_r);
    end
  end

  assign stat.out_blocked = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_data_r;
  assign out_status       = out_status_r;
  assign out_now_empty    = out_empty_r;
  assign out_now_full     = out_full_r;
  assign out_occupancy    = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Word count exceeds the ring depth.");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= IW'(DEPTH - 1))
    else $error("Head index left the ring.");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && ram_we |=> count_r == $past(count_r) + CW'(1))
    else $error("Accepted push did not add one word.");

  a_read_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && ram_re && op_r != dq_pkg::OP_PEEK_FRONT
      |=> count_r == $past(count_r) - CW'(1))
    else $error("Accepted pop did not remove one word.");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("Result register loaded without raising valid.");

endmodule
